FILE: sv/csvp_pkg.sv
// csvp_pkg: types, character codes and per-byte parse helpers for the CSV byte parser.
// Used by the output channel interface, csvp_step and csv_byte_parser_unit; depends on nothing.
package csvp_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam int unsigned MAX_RES = 4;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_CELL_END  = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_TABLE_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_SKIP = 2'd0,  // line start / before a cell, skipping blanks
    MODE_UNQ  = 2'd1,  // inside an unquoted cell
    MODE_QIN  = 2'd2,  // inside a quoted cell
    MODE_QEND = 2'd3   // quoted cell, just saw a quote
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  cr_held;
    logic  line_has_bytes;
    logic  cell_quoted;
    logic  in_header_row;
    logic  table_done;
    logic  first_line;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  content;
    logic        cell_quoted;
    logic        header_row;
  } result_t;

  function automatic state_t rearm_state(input logic has_header);
    state_t s;
    s.mode           = MODE_SKIP;
    s.cr_held        = 1'b0;
    s.line_has_bytes = 1'b0;
    s.cell_quoted    = 1'b0;
    s.in_header_row  = has_header;
    s.table_done     = 1'b0;
    s.first_line     = 1'b1;
    return s;
  endfunction

  function automatic result_t cell_end(input state_t s);
    result_t r;
    r.kind        = KIND_CELL_END;
    r.content     = 8'h00;
    r.cell_quoted = s.cell_quoted;
    r.header_row  = s.in_header_row;
    return r;
  endfunction

  function automatic result_t row_end(input state_t s);
    result_t r;
    r.kind        = KIND_ROW_END;
    r.content     = 8'h00;
    r.cell_quoted = 1'b0;
    r.header_row  = s.in_header_row;
    return r;
  endfunction

  function automatic result_t table_end();
    result_t r;
    r.kind        = KIND_TABLE_END;
    r.content     = 8'h00;
    r.cell_quoted = 1'b0;
    r.header_row  = 1'b0;
    return r;
  endfunction

  // One non-newline byte; gives at most one result.
  function automatic void parse_byte(input state_t s_i, input logic [7:0] b,
                                     output state_t s_o, output result_t r,
                                     output logic rv);
    s_o = s_i;
    s_o.line_has_bytes = 1'b1;
    rv = 1'b0;
    r.kind        = KIND_CONTENT;
    r.content     = b;
    r.cell_quoted = s_i.cell_quoted;
    r.header_row  = s_i.in_header_row;
    case (s_i.mode)
      MODE_UNQ: begin
        rv = 1'b1;
        if (b == CH_COMMA) begin
          r = cell_end(s_i);
          s_o.cell_quoted = 1'b0;
          s_o.mode = MODE_SKIP;
        end
      end
      MODE_QIN: begin
        if (b == CH_QUOTE) s_o.mode = MODE_QEND;
        else rv = 1'b1;
      end
      MODE_QEND: begin
        rv = 1'b1;
        if (b == CH_COMMA) begin
          r = cell_end(s_i);
          s_o.cell_quoted = 1'b0;
          s_o.mode = MODE_SKIP;
        end else begin
          // doubled quote gives one quote; any other byte continues the cell
          s_o.mode = MODE_QIN;
        end
      end
      default: begin
        s_o.mode = MODE_SKIP;
        if (b == CH_SP || b == CH_TAB) begin
          s_o.mode = MODE_SKIP;
        end else if (b == CH_QUOTE) begin
          s_o.cell_quoted = 1'b1;
          s_o.mode = MODE_QIN;
        end else if (b == CH_COMMA) begin
          s_o.cell_quoted = 1'b0;
          r = cell_end(s_o);
          rv = 1'b1;
        end else begin
          s_o.cell_quoted = 1'b0;
          s_o.mode = MODE_UNQ;
          r.cell_quoted = 1'b0;
          rv = 1'b1;
        end
      end
    endcase
  endfunction

endpackage

FILE: sv/csvp_ifs.sv
// Valid/ready channel interfaces for the CSV byte parser: byte input and result output.
// Depends on csvp_pkg.
interface csvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface csvp_out_if import csvp_pkg::*;;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] content;
  logic       cell_quoted;
  logic       header_row;
  logic       last;

  modport source (output valid, output kind, output content, output cell_quoted,
                  output header_row, output last, input ready);
  modport sink   (input valid, input kind, input content, input cell_quoted,
                  input header_row, input last, output ready);
endinterface

FILE: sv/csvp_step.sv
// csvp_step: combinational next-state and result list for one input transaction.
// Depends on csvp_pkg.
module csvp_step import csvp_pkg::*; (
  input  state_t                  cur,
  input  logic                    has_header,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_data,
  output state_t                  nxt,
  output result_t [MAX_RES-1:0]   res,
  output logic [2:0]              count
);

  state_t  s;
  state_t  s2;
  result_t r;
  logic    rv;

  always_comb begin
    s = cur;
    s2 = cur;
    r = '0;
    rv = 1'b0;
    res = '0;
    count = 3'd0;
    if (end_of_data) begin
      if (!s.table_done) begin
        if (s.line_has_bytes) begin
          if (s.mode != MODE_SKIP) begin
            res[count[1:0]] = cell_end(s);
            count = count + 3'd1;
          end
          res[count[1:0]] = row_end(s);
          count = count + 3'd1;
        end
        res[count[1:0]] = table_end();
        count = count + 3'd1;
      end
      s = rearm_state(has_header);
    end else if (s.table_done) begin
      s = cur;  // discard until end of data
    end else if (data_byte == CH_NL) begin
      s.cr_held = 1'b0;
      if (!s.line_has_bytes) begin
        if (s.in_header_row) begin
          res[count[1:0]] = row_end(s);
          count = count + 3'd1;
          s.mode = MODE_SKIP;
          s.cell_quoted = 1'b0;
          s.in_header_row = 1'b0;
          s.first_line = 1'b0;
        end else begin
          // blank line ends the table
          res[count[1:0]] = table_end();
          count = count + 3'd1;
          s.table_done = 1'b1;
          s.mode = MODE_SKIP;
          s.cell_quoted = 1'b0;
        end
      end else begin
        if (s.mode != MODE_SKIP) begin
          res[count[1:0]] = cell_end(s);
          count = count + 3'd1;
          s.cell_quoted = 1'b0;
        end
        res[count[1:0]] = row_end(s);
        count = count + 3'd1;
        s.mode = MODE_SKIP;
        s.line_has_bytes = 1'b0;
        s.cell_quoted = 1'b0;
        s.in_header_row = 1'b0;
        s.first_line = 1'b0;
      end
    end else begin
      // a held CR not followed by newline is an ordinary byte
      if (s.cr_held) begin
        s.cr_held = 1'b0;
        parse_byte(s, CH_CR, s2, r, rv);
        s = s2;
        if (rv) begin
          res[count[1:0]] = r;
          count = count + 3'd1;
        end
      end
      if (data_byte == CH_CR) begin
        s.cr_held = 1'b1;
      end else begin
        parse_byte(s, data_byte, s2, r, rv);
        s = s2;
        if (rv) begin
          res[count[1:0]] = r;
          count = count + 3'd1;
        end
      end
    end
    nxt = s;
  end

endmodule

FILE: sv/csv_byte_parser_unit.sv
// csv_byte_parser_unit: top level of the streaming CSV byte parser.
// Depends on csvp_pkg, csvp_ifs (channel interfaces) and csvp_step.

// The parser takes one byte (or an end-of-data mark) per transaction and turns it into
// zero to three results: content bytes, end of cell, end of row and end of table. Each
// input byte is resolved combinationally by csvp_step and its results are loaded into a
// small result buffer that drains one result per cycle to the output while it is ready; the
// last result of each input carries last. A new byte is accepted whenever the buffer is
// empty or its final pending result is taken in the same cycle, so bytes that give at
// most one result stream at one per cycle while the output is ready; a byte with more
// results holds off the next. has_header may be written only while the parser is idle.
module csv_byte_parser_unit import csvp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  csvp_in_if.sink       byte_in,
  csvp_out_if.source    result_out
);

  logic                    has_header;
  state_t                  state;
  state_t                  state_next;
  result_t [MAX_RES-1:0]   step_res;
  logic [2:0]              step_count;
  result_t [MAX_RES-1:0]   res_buf;
  logic [2:0]              pending;
  logic [1:0]              rd_idx;
  logic                    pop;
  logic                    drain_done;
  logic                    accept;
  result_t                 cur_res;

  csvp_step u_step (
    .cur         (state),
    .has_header  (has_header),
    .data_byte   (byte_in.data_byte),
    .end_of_data (byte_in.end_of_data),
    .nxt         (state_next),
    .res         (step_res),
    .count       (step_count)
  );

  assign cur_res    = res_buf[rd_idx];
  assign pop        = result_out.valid && result_out.ready;
  assign drain_done = pop && ({1'b0, rd_idx} == pending - 3'd1);
  assign accept     = byte_in.valid && byte_in.ready;

  assign byte_in.ready          = (pending == 3'd0) || drain_done;
  assign result_out.valid       = (pending != 3'd0);
  assign result_out.kind        = cur_res.kind;
  assign result_out.content     = cur_res.content;
  assign result_out.cell_quoted = cur_res.cell_quoted;
  assign result_out.header_row  = cur_res.header_row;
  assign result_out.last        = ({1'b0, rd_idx} == pending - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      has_header <= 1'b0;
      state      <= rearm_state(1'b0);
      pending    <= 3'd0;
      rd_idx     <= 2'd0;
    end else begin
      if (accept) begin
        state   <= state_next;
        res_buf <= step_res;
        pending <= step_count;
        rd_idx  <= 2'd0;
      end else begin
        if (pop) begin
          if (drain_done) pending <= 3'd0;
          else rd_idx <= rd_idx + 2'd1;
        end
        // header flag follows the register until the first row of a table ends
        if (cfg_write && state.first_line) state.in_header_row <= cfg_data;
      end
      if (cfg_write) has_header <= cfg_data;
    end
  end

endmodule
